>>> rtl/mbrs_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave package
// Shared constants, codes, controller types and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrs_pkg;

  // Default sizes of the holding register file and of one read request.
  localparam int unsigned REG_COUNT_DEF      = 16;
  localparam int unsigned MAX_READ_COUNT_DEF = 2;

  // Frame layout: six bytes are covered by the CRC, eight bytes in total.
  localparam int unsigned CRC_SPAN  = 6;
  localparam int unsigned FRAME_LEN = 8;

  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd1;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  // Function codes that the slave serves.
  localparam logic [7:0] FN_READ  = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_RD_ADDR,
    ST_RD_FUNC,
    ST_RD_COUNT,
    ST_FETCH,
    ST_RD_HI,
    ST_RD_LO,
    ST_CRC_LO,
    ST_CRC_HI,
    ST_ECHO
  } mbrs_state_t;

  // Source of the byte put on the response port.
  typedef enum logic [2:0] {
    SRC_ADDR,
    SRC_FUNC,
    SRC_COUNT,
    SRC_DATA_HI,
    SRC_DATA_LO,
    SRC_CRC_LO,
    SRC_CRC_HI,
    SRC_RX
  } emit_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_frame;
    logic      crc_init;
    logic      crc_step;
    logic      crc_from_tx;
    logic      idx_clear;
    logic      idx_inc;
    logic      clr_write;
    logic      reg_write;
    logic      read_setup;
    logic      fetch;
    logic      emit;
    logic      emit_last;
    emit_src_t src;
  } mbrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       frame_ok;
    logic       is_read;
    logic       is_write;
    logic       read_ok;
    logic       write_in_range;
    logic       words_done;
    logic       clear_done;
    logic [2:0] idx;
  } mbrs_status_t;

  // One byte of the reflected Modbus CRC-16.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/mbrs_ctrl.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave controller
// Sequences register clearing, CRC check, decision and response bytes.
// ----------------------------------------------------------------------------
module mbrs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  mbrs_pkg::mbrs_status_t status,
  output mbrs_pkg::mbrs_cmd_t    cmd
);
  import mbrs_pkg::*;

  mbrs_state_t state;
  mbrs_state_t state_next;

  localparam logic [2:0] IDX_CRC_LAST   = 3'(CRC_SPAN - 1);
  localparam logic [2:0] IDX_FRAME_LAST = 3'(FRAME_LEN - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.idx == IDX_CRC_LAST) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.frame_ok && status.is_read && status.read_ok) begin
          state_next = ST_RD_ADDR;
        end else if (status.frame_ok && status.is_write) begin
          state_next = ST_ECHO;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RD_ADDR:  state_next = ST_RD_FUNC;
      ST_RD_FUNC:  state_next = ST_RD_COUNT;
      ST_RD_COUNT: state_next = ST_FETCH;
      ST_FETCH:    state_next = ST_RD_HI;
      ST_RD_HI:    state_next = ST_RD_LO;
      ST_RD_LO: begin
        if (status.words_done) begin
          state_next = ST_CRC_LO;
        end else begin
          state_next = ST_FETCH;
        end
      end
      ST_CRC_LO: state_next = ST_CRC_HI;
      ST_CRC_HI: state_next = ST_IDLE;
      ST_ECHO: begin
        if (status.idx == IDX_FRAME_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    cmd.src = SRC_RX;
    busy = (state != ST_IDLE);
    case (state)
      ST_CLEAR: begin
        cmd.clr_write = 1'b1;
      end
      ST_IDLE: begin
        cmd.load_frame = start;
        cmd.crc_init   = start;
        cmd.idx_clear  = start;
      end
      ST_CHECK: begin
        cmd.crc_step = 1'b1;
        cmd.idx_inc  = 1'b1;
      end
      ST_DECIDE: begin
        cmd.crc_init   = 1'b1;
        cmd.read_setup = 1'b1;
        cmd.idx_clear  = 1'b1;
        cmd.reg_write  = status.frame_ok && status.is_write && status.write_in_range;
      end
      ST_RD_ADDR: begin
        cmd.emit = 1'b1; cmd.src = SRC_ADDR;
        cmd.crc_step = 1'b1; cmd.crc_from_tx = 1'b1;
      end
      ST_RD_FUNC: begin
        cmd.emit = 1'b1; cmd.src = SRC_FUNC;
        cmd.crc_step = 1'b1; cmd.crc_from_tx = 1'b1;
      end
      ST_RD_COUNT: begin
        cmd.emit = 1'b1; cmd.src = SRC_COUNT;
        cmd.crc_step = 1'b1; cmd.crc_from_tx = 1'b1;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_RD_HI: begin
        cmd.emit = 1'b1; cmd.src = SRC_DATA_HI;
        cmd.crc_step = 1'b1; cmd.crc_from_tx = 1'b1;
      end
      ST_RD_LO: begin
        cmd.emit = 1'b1; cmd.src = SRC_DATA_LO;
        cmd.crc_step = 1'b1; cmd.crc_from_tx = 1'b1;
      end
      ST_CRC_LO: begin
        cmd.emit = 1'b1; cmd.src = SRC_CRC_LO;
      end
      ST_CRC_HI: begin
        cmd.emit = 1'b1; cmd.src = SRC_CRC_HI; cmd.emit_last = 1'b1;
      end
      ST_ECHO: begin
        cmd.emit      = 1'b1;
        cmd.src       = SRC_RX;
        cmd.idx_inc   = 1'b1;
        cmd.emit_last = (status.idx == IDX_FRAME_LAST);
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/mbrs_datapath.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave datapath
// Frame registers, CRC unit, holding register memory and response register.
// ----------------------------------------------------------------------------
module mbrs_datapath #(
  parameter int unsigned REG_COUNT      = mbrs_pkg::REG_COUNT_DEF,
  parameter int unsigned MAX_READ_COUNT = mbrs_pkg::MAX_READ_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [7:0]             cfg_data,
  input  logic [7:0]             frame_address,
  input  logic [7:0]             function_code,
  input  logic [15:0]            first_word,
  input  logic [15:0]            second_word,
  input  logic [7:0]             crc_first,
  input  logic [7:0]             crc_second,
  input  mbrs_pkg::mbrs_cmd_t    cmd,
  output mbrs_pkg::mbrs_status_t status,
  output logic [7:0]             response_byte,
  output logic                   last_byte,
  output logic                   strobe
);
  import mbrs_pkg::*;

  localparam int unsigned AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned CW = $clog2(MAX_READ_COUNT + 1);

  logic [7:0]    slave_address;
  logic [7:0]    rx_addr;
  logic [7:0]    rx_func;
  logic [15:0]   rx_first;
  logic [15:0]   rx_second;
  logic [7:0]    rx_crc_a;
  logic [7:0]    rx_crc_b;
  logic [15:0]   crc;
  logic [2:0]    idx;
  logic [15:0]   addr;
  logic [CW-1:0] words_left;
  logic [15:0]   mem_q;
  logic [15:0]   mem [REG_COUNT];

  logic [7:0]    rx_byte;
  logic [7:0]    tx_byte;
  logic [7:0]    crc_byte;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDR_RST;
    end else if (cfg_valid) begin
      slave_address <= cfg_data;
    end
  end

  // Request frame.
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      rx_addr   <= frame_address;
      rx_func   <= function_code;
      rx_first  <= first_word;
      rx_second <= second_word;
      rx_crc_a  <= crc_first;
      rx_crc_b  <= crc_second;
    end
  end

  always_comb begin
    case (idx)
      3'd0:    rx_byte = rx_addr;
      3'd1:    rx_byte = rx_func;
      3'd2:    rx_byte = rx_first[15:8];
      3'd3:    rx_byte = rx_first[7:0];
      3'd4:    rx_byte = rx_second[15:8];
      3'd5:    rx_byte = rx_second[7:0];
      3'd6:    rx_byte = rx_crc_a;
      3'd7:    rx_byte = rx_crc_b;
      default: rx_byte = rx_addr;
    endcase
  end

  always_comb begin
    case (cmd.src)
      SRC_ADDR:    tx_byte = slave_address;
      SRC_FUNC:    tx_byte = FN_READ;
      SRC_COUNT:   tx_byte = {rx_second[6:0], 1'b0};
      SRC_DATA_HI: tx_byte = mem_q[15:8];
      SRC_DATA_LO: tx_byte = mem_q[7:0];
      SRC_CRC_LO:  tx_byte = crc[7:0];
      SRC_CRC_HI:  tx_byte = crc[15:8];
      SRC_RX:      tx_byte = rx_byte;
      default:     tx_byte = rx_byte;
    endcase
  end

  assign crc_byte = cmd.crc_from_tx ? tx_byte : rx_byte;

  // One CRC byte per cycle, shared by the check and the read response.
  always_ff @(posedge clk) begin
    if (cmd.crc_init) begin
      crc <= CRC_INIT;
    end else if (cmd.crc_step) begin
      crc <= crc16_byte(crc, crc_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 3'd1;
    end
  end

  // The address counter walks the memory during the clearing pass and the
  // registers of a read request afterwards.
  always_ff @(posedge clk) begin
    if (rst) begin
      addr       <= '0;
      words_left <= '0;
    end else if (cmd.clr_write || cmd.fetch) begin
      addr <= addr + 16'd1;
      if (cmd.fetch) begin
        words_left <= words_left - CW'(1);
      end
    end else if (cmd.read_setup) begin
      addr       <= rx_first;
      words_left <= rx_second[CW-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.clr_write || cmd.reg_write;
    wr_addr = cmd.clr_write ? addr[AW-1:0] : rx_first[AW-1:0];
    wr_data = cmd.clr_write ? 16'h0000 : rx_second;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mem_q <= mem[addr[AW-1:0]];
    end
  end

  always_comb begin
    status.frame_ok = (rx_addr == slave_address) &&
                      (((rx_crc_a == crc[7:0]) && (rx_crc_b == crc[15:8])) ||
                       ((rx_crc_a == crc[15:8]) && (rx_crc_b == crc[7:0])));
    status.is_read  = (rx_func == FN_READ);
    status.is_write = (rx_func == FN_WRITE);
    status.read_ok  = (({1'b0, rx_first} + {1'b0, rx_second}) <= 17'(REG_COUNT)) &&
                      (rx_second != 16'd0) &&
                      (rx_second <= 16'(MAX_READ_COUNT));
    status.write_in_range = ({1'b0, rx_first} < 17'(REG_COUNT));
    status.words_done     = (words_left == '0);
    status.clear_done     = (addr == 16'(REG_COUNT - 1));
    status.idx            = idx;
  end

  // Response register: each byte is shown for exactly one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe    <= 1'b0;
      last_byte <= 1'b0;
    end else begin
      strobe    <= cmd.emit;
      last_byte <= cmd.emit && cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      response_byte <= tx_byte;
    end
  end

endmodule

>>> rtl/modbus_rtu_register_slave_unit.sv
// ----------------------------------------------------------------------------
// Modbus RTU register slave unit
// Serves read (03) and single write (06) requests on a holding register file.
// ----------------------------------------------------------------------------
// A request frame is taken whole at a clock edge where start is high and busy
// is low. The response leaves one byte per beat on response_byte, each beat
// marked by strobe for exactly one cycle and with last_byte set on the final
// byte; there is no backpressure, so the receiver must take every byte as it
// appears. Frames with a foreign station address, a bad CRC (either byte order
// of the received CRC is accepted), an unknown function code or an invalid
// read range produce no bytes at all. After reset the unit sweeps the register
// file to zero, one register per cycle, while busy stays high; configuration
// writes are taken during that time as always.
//
// Sequence per frame, set by the controller and the single CRC unit that
// folds one byte per cycle: a CRC check over six bytes and a decision step,
// then for a write an 8-byte echo at one byte per cycle, and for a read of N
// registers 3 header bytes, per register one memory read step and two data
// bytes, and 2 CRC bytes. A dropped frame keeps the unit busy through the
// check and the decision. The unit is ready for the next frame in the same
// cycle in which its last byte is shown.
//
// The slave address register is written through cfg_valid / cfg_data and
// resets to 1. It is to be written only while the unit is not busy.
module modbus_rtu_register_slave_unit #(
  parameter int unsigned REG_COUNT      = mbrs_pkg::REG_COUNT_DEF,
  parameter int unsigned MAX_READ_COUNT = mbrs_pkg::MAX_READ_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request frame channel.
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  frame_address,
  input  logic [7:0]  function_code,
  input  logic [15:0] first_word,
  input  logic [15:0] second_word,
  input  logic [7:0]  crc_first,
  input  logic [7:0]  crc_second,
  // Response byte channel.
  output logic        strobe,
  output logic [7:0]  response_byte,
  output logic        last_byte,
  // Slave address configuration channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import mbrs_pkg::*;

  mbrs_cmd_t    cmd;
  mbrs_status_t status;

  // The configuration register can always take a beat.
  assign cfg_ready = 1'b1;

  mbrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  mbrs_datapath #(
    .REG_COUNT      (REG_COUNT),
    .MAX_READ_COUNT (MAX_READ_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .frame_address (frame_address),
    .function_code (function_code),
    .first_word    (first_word),
    .second_word   (second_word),
    .crc_first     (crc_first),
    .crc_second    (crc_second),
    .cmd           (cmd),
    .status        (status),
    .response_byte (response_byte),
    .last_byte     (last_byte),
    .strobe        (strobe)
  );

endmodule
